/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/bgsps_pkg.sv */
// ---------------------------------------------------------------------------
// bgsps_pkg
// Constants and register indexes of the burst/gap pulse sequencer.
// ---------------------------------------------------------------------------
package bgsps_pkg;

  localparam int unsigned TICK_US    = 10;
  localparam int unsigned NODE_COUNT = 8;
  localparam int unsigned TICK_W     = $clog2(TICK_US + 1);

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PW_W   = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned AMP_W  = 12;
  localparam int unsigned NODE_W = 4;
  localparam int unsigned SW_W   = 16;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_PULSE_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_BURST       = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAP         = 3'd2;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_NODE_PLUS   = 3'd4;
  localparam logic [IDX_W-1:0] REG_NODE_MINUS  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HOLD        = 3'd6;

  localparam logic [PW_W-1:0]   PULSE_WIDTH_RST = 16'd500;
  localparam logic [TIME_W-1:0] BURST_RST       = 24'd50000;
  localparam logic [TIME_W-1:0] GAP_RST         = 24'd0;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 12'd1613;
  localparam logic [NODE_W-1:0] NODE_PLUS_RST   = 4'd1;
  localparam logic [NODE_W-1:0] NODE_MINUS_RST  = 4'd8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = (n >= NODE_W'(1)) && (n <= NODE_W'(NODE_COUNT));
  endfunction

endpackage

/* design/burst_gap_stimulation_pulse_sequencer_core.sv */
// ---------------------------------------------------------------------------
// burst_gap_stimulation_pulse_sequencer_core
// Biphasic pulse sequencer with burst/gap gating and switch matrix decode.
// ---------------------------------------------------------------------------
// Each input beat carries one tick flag and yields one result beat holding
// the bridge, DAC, LED and switch matrix levels after that tick. A beat is
// taken every cycle unless in_stall is high; it passes the input register,
// then the result register, which out_stall may hold; the counters, the two
// 16x16 burst/gap products and their compares settle in the single logic
// stage between those registers.
// Configuration writes are taken at any time but only while no beat is in
// flight do they give defined results.
`include "assert_macros.svh"

module burst_gap_stimulation_pulse_sequencer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bgsps_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bgsps_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 bridge_enable,
  output logic                                 polarity,
  output logic [bgsps_pkg::AMP_W-1:0]          dac_value,
  output logic                                 led_state,
  output logic [bgsps_pkg::SW_W-1:0]           switch_word,
  output logic                                 nodes_valid
);

  localparam int unsigned CNT_W  = bgsps_pkg::CNT_W;
  localparam int unsigned PW_W   = bgsps_pkg::PW_W;
  localparam int unsigned TIME_W = bgsps_pkg::TIME_W;
  localparam int unsigned AMP_W  = bgsps_pkg::AMP_W;
  localparam int unsigned NODE_W = bgsps_pkg::NODE_W;
  localparam int unsigned SW_W   = bgsps_pkg::SW_W;
  localparam int unsigned TICK_W = bgsps_pkg::TICK_W;
  localparam int unsigned TP_W   = CNT_W + 1 + TICK_W;
  localparam int unsigned PROD_W = CNT_W + PW_W;

  // configuration
  logic [PW_W-1:0]   pulse_width_us;
  logic [TIME_W-1:0] burst_us;
  logic [TIME_W-1:0] gap_us;
  logic [AMP_W-1:0]  amplitude_code;
  logic [NODE_W-1:0] node_plus;
  logic [NODE_W-1:0] node_minus;
  logic              hold_mode;

  // sequencer state
  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [CNT_W-1:0] pulse_count, pulse_count_next;
  logic [CNT_W-1:0] gap_count, gap_count_next;
  logic             in_gap, in_gap_next;
  logic             bridge_polarity, bridge_polarity_next;
  logic             led_level, led_level_next;

  // input register, handshake and switch decode signals
  logic in_full;
  logic in_advance;
  logic move;
  logic sw_valid;
  logic [SW_W-1:0] sw_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_us <= bgsps_pkg::PULSE_WIDTH_RST;
      burst_us       <= bgsps_pkg::BURST_RST;
      gap_us         <= bgsps_pkg::GAP_RST;
      amplitude_code <= bgsps_pkg::AMPLITUDE_RST;
      node_plus      <= bgsps_pkg::NODE_PLUS_RST;
      node_minus     <= bgsps_pkg::NODE_MINUS_RST;
      hold_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgsps_pkg::REG_PULSE_WIDTH: pulse_width_us <= cfg_data[PW_W-1:0];
        bgsps_pkg::REG_BURST:       burst_us       <= cfg_data[TIME_W-1:0];
        bgsps_pkg::REG_GAP:         gap_us         <= cfg_data[TIME_W-1:0];
        bgsps_pkg::REG_AMPLITUDE:   amplitude_code <= cfg_data[AMP_W-1:0];
        bgsps_pkg::REG_NODE_PLUS:   node_plus      <= cfg_data[NODE_W-1:0];
        bgsps_pkg::REG_NODE_MINUS:  node_minus     <= cfg_data[NODE_W-1:0];
        bgsps_pkg::REG_HOLD:        hold_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_advance <= advance;
    end
  end

  always_comb begin
    logic [CNT_W-1:0]  t1;
    logic [TP_W-1:0]   tick_span;
    logic [CNT_W-1:0]  pc1;
    logic [CNT_W-1:0]  gc1;
    logic [PROD_W-1:0] burst_prod;
    logic [PROD_W-1:0] gap_prod;
    logic              period_done;
    logic              gap_hit;
    logic              gap_done;

    t1         = bgsps_pkg::sat_inc(tick_count);
    // period ends once t1 >= floor(pw / TICK_US), i.e. (t1 + 1) * TICK_US > pw
    tick_span  = TP_W'({1'b0, t1} + (CNT_W + 1)'(1)) * TP_W'(bgsps_pkg::TICK_US);
    pc1        = bgsps_pkg::sat_inc(pulse_count);
    gc1        = bgsps_pkg::sat_inc(gap_count);
    burst_prod = PROD_W'(pc1) * PROD_W'(pulse_width_us);
    gap_prod   = PROD_W'(gc1) * PROD_W'(pulse_width_us);
    period_done = tick_span > TP_W'(pulse_width_us);
    gap_hit    = (burst_prod >= PROD_W'(burst_us)) && (gap_us != '0);
    gap_done   = gap_prod >= PROD_W'(gap_us);

    tick_count_next      = tick_count;
    pulse_count_next     = pulse_count;
    gap_count_next       = gap_count;
    in_gap_next          = in_gap;
    bridge_polarity_next = bridge_polarity;
    led_level_next       = led_level;

    if (in_advance && !hold_mode) begin
      if (period_done) begin
        tick_count_next = '0;
        if (gap_hit) begin
          if (gap_done) begin
            in_gap_next          = 1'b0;
            gap_count_next       = '0;
            pulse_count_next     = '0;
            bridge_polarity_next = 1'b0;
          end else begin
            in_gap_next      = 1'b1;
            gap_count_next   = gc1;
            pulse_count_next = pc1;
          end
        end else begin
          in_gap_next          = 1'b0;
          gap_count_next       = '0;
          pulse_count_next     = pc1;
          bridge_polarity_next = !bridge_polarity;
          led_level_next       = !led_level;
        end
      end else begin
        tick_count_next = t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      pulse_count     <= '0;
      gap_count       <= '0;
      in_gap          <= 1'b0;
      bridge_polarity <= 1'b0;
      led_level       <= 1'b0;
    end else if (move) begin
      tick_count      <= tick_count_next;
      pulse_count     <= pulse_count_next;
      gap_count       <= gap_count_next;
      in_gap          <= in_gap_next;
      bridge_polarity <= bridge_polarity_next;
      led_level       <= led_level_next;
    end
  end

  // switch matrix decode
  assign sw_valid = bgsps_pkg::node_ok(node_plus) && bgsps_pkg::node_ok(node_minus)
                    && (node_plus != node_minus);
  assign sw_word  = sw_valid ? ((SW_W'(1) << (node_plus - NODE_W'(1)))
                              | (SW_W'(1) << (SW_W'(node_minus) + SW_W'(7))))
                             : '0;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      bridge_enable <= !in_gap_next;
      polarity      <= in_gap_next ? 1'b0 : bridge_polarity_next;
      dac_value     <= in_gap_next ? '0 : amplitude_code;
      led_state     <= led_level_next;
      switch_word   <= sw_word;
      nodes_valid   <= sw_valid;
    end
  end

  `ASSERT_CLK(a_gap_output_quiet, clk, rst,
    (out_valid && !bridge_enable) |-> (dac_value == '0 && !polarity),
    "gap beat drives current or polarity")
  `ASSERT_CLK(a_switch_matches_valid, clk, rst,
    out_valid |-> (nodes_valid == (switch_word != '0)),
    "switch word disagrees with node check")
  `ASSERT_CLK(a_gap_count_in_gap, clk, rst,
    (gap_count != '0) |-> in_gap,
    "gap counter running outside a gap")
  `ASSERT_CLK(a_hold_freezes, clk, rst,
    (move && hold_mode) |=> (tick_count == $past(tick_count)
                             && led_level == $past(led_level)),
    "state moved while held")
  `ASSERT_CLK(a_full_stalled, clk, rst,
    (in_full && out_valid && out_stall) |-> in_stall,
    "input taken while result stage blocked")

endmodule

/* test/tb_burst_gap_stimulation_pulse_sequencer_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_burst_gap_stimulation_pulse_sequencer_core
// Self-checking bench for the burst/gap biphasic pulse sequencer. A queue of
// tick beats and register writes feeds a clocked driver. The driver predicts
// every result beat from its own copy of the sequencer state. A clocked
// monitor applies random back-pressure and compares each result beat, field
// by field, with the oldest prediction. Register writes happen only while
// the pipeline is empty. The stimulus covers directed corner settings, a
// short back-to-back run without back-pressure and randomized burst/gap
// settings.
// ---------------------------------------------------------------------------
module tb_burst_gap_stimulation_pulse_sequencer_core;
  import bgsps_pkg::*;

  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned RUSH_BEATS  = 30;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 100;

  typedef struct packed {
    logic              bridge;
    logic              pol;
    logic [AMP_W-1:0]  dac;
    logic              led;
    logic [SW_W-1:0]   sw;
    logic              nv;
  } seq_out_t;

  typedef struct {
    logic              is_write;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  data;
    logic              adv;
    logic              quick;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_PULSE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic advance = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic bridge_enable;
  logic polarity;
  logic [AMP_W-1:0] dac_value;
  logic led_state;
  logic [SW_W-1:0] switch_word;
  logic nodes_valid;

  burst_gap_stimulation_pulse_sequencer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bridge_enable (bridge_enable),
    .polarity      (polarity),
    .dac_value     (dac_value),
    .led_state     (led_state),
    .switch_word   (switch_word),
    .nodes_valid   (nodes_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer copy: settings
  logic [PW_W-1:0]   m_pw;
  logic [TIME_W-1:0] m_burst;
  logic [TIME_W-1:0] m_gap;
  logic [AMP_W-1:0]  m_amp;
  logic [NODE_W-1:0] m_np;
  logic [NODE_W-1:0] m_nm;
  logic              m_hold;
  // sequencer copy: state
  logic [CNT_W-1:0]  m_tick;
  logic [CNT_W-1:0]  m_pulse;
  logic [CNT_W-1:0]  m_gapc;
  logic              m_in_gap;
  logic              m_pol;
  logic              m_led;

  stim_t    pending_q[$];
  seq_out_t levels_q[$];

  logic rush = 1'b0;
  int   errors = 0;
  int   writes_done = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   gap_results = 0;
  int   cycles = 0;

  function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
    bump16 = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic node_in_range(input logic [NODE_W-1:0] n);
    node_in_range = (n >= NODE_W'(1)) && (int'(n) <= NODE_COUNT);
  endfunction

  task automatic reset_sequencer();
    m_pw     = PULSE_WIDTH_RST;
    m_burst  = BURST_RST;
    m_gap    = GAP_RST;
    m_amp    = AMPLITUDE_RST;
    m_np     = NODE_PLUS_RST;
    m_nm     = NODE_MINUS_RST;
    m_hold   = 1'b0;
    m_tick   = '0;
    m_pulse  = '0;
    m_gapc   = '0;
    m_in_gap = 1'b0;
    m_pol    = 1'b0;
    m_led    = 1'b0;
  endtask

  task automatic load_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    unique case (idx)
      REG_PULSE_WIDTH: m_pw = val[PW_W-1:0];
      REG_BURST:       m_burst = val[TIME_W-1:0];
      REG_GAP:         m_gap = val[TIME_W-1:0];
      REG_AMPLITUDE:   m_amp = val[AMP_W-1:0];
      REG_NODE_PLUS:   m_np = val[NODE_W-1:0];
      REG_NODE_MINUS:  m_nm = val[NODE_W-1:0];
      REG_HOLD:        m_hold = val[0];
      default: ;
    endcase
  endtask

  task automatic step_sequencer(input logic adv, output seq_out_t r);
    logic [31:0] prod;
    logic        nv;
    logic [SW_W-1:0] sw;
    if (adv && !m_hold) begin
      m_tick = bump16(m_tick);
      if (m_tick >= (m_pw / PW_W'(TICK_US))) begin
        m_pulse = bump16(m_pulse);
        prod = 32'(m_pulse) * 32'(m_pw);
        if (prod >= 32'(m_burst) && m_gap != '0) begin
          m_in_gap = 1'b1;
          m_gapc = bump16(m_gapc);
          prod = 32'(m_gapc) * 32'(m_pw);
          if (prod >= 32'(m_gap)) begin
            m_in_gap = 1'b0;
            m_gapc   = '0;
            m_pulse  = '0;
            m_pol    = 1'b0;
          end
        end else begin
          m_in_gap = 1'b0;
          m_gapc   = '0;
          m_pol    = ~m_pol;
          m_led    = ~m_led;
        end
        m_tick = '0;
      end
    end
    nv = node_in_range(m_np) && node_in_range(m_nm) && (m_np != m_nm);
    sw = '0;
    if (nv) begin
      sw = (SW_W'(1) << (int'(m_np) - 1)) | (SW_W'(1) << (int'(m_nm) + 7));
    end
    r.bridge = ~m_in_gap;
    r.pol    = m_in_gap ? 1'b0 : m_pol;
    r.dac    = m_in_gap ? '0 : m_amp;
    r.led    = m_led;
    r.sw     = sw;
    r.nv     = nv;
  endtask

  task automatic push_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_t s;
    s.is_write = 1'b1;
    s.idx      = idx;
    s.data     = val;
    s.adv      = 1'b0;
    s.quick    = 1'b0;
    pending_q.push_back(s);
  endtask

  task automatic push_tick(input logic adv, input logic quick);
    stim_t s;
    s.is_write = 1'b0;
    s.idx      = REG_PULSE_WIDTH;
    s.data     = '0;
    s.adv      = adv;
    s.quick    = quick;
    pending_q.push_back(s);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_tick(1'b1, 1'b0);
  endtask

  // driver: present beats, predict at acceptance, write registers when drained
  int    gap_left = 0;
  int    quiet = 0;
  always @(posedge clk) begin
    logic     valid_n;
    logic     we_n;
    stim_t    s;
    seq_out_t r;
    if (rst) begin
      reset_sequencer();
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      gap_left = 0;
      quiet    = 0;
    end else begin
      valid_n = in_valid;
      we_n    = 1'b0;
      if (in_valid && !in_stall) begin
        step_sequencer(advance, r);
        levels_q.push_back(r);
        beats_sent++;
        valid_n = 1'b0;
      end
      if (in_valid || levels_q.size() > 0) quiet = 0;
      else quiet++;
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          if (!pending_q[0].is_write) begin
            s = pending_q.pop_front();
            valid_n = 1'b1;
            advance <= s.adv;
            rush    <= s.quick;
            gap_left = s.quick ? 0 : $urandom_range(0, 10);
          end else if (!in_valid && quiet >= SETTLE) begin
            s = pending_q.pop_front();
            we_n = 1'b1;
            cfg_index <= s.idx;
            cfg_data  <= s.data;
            load_register(s.idx, s.data);
            writes_done++;
          end
        end
      end
      in_valid <= valid_n;
      cfg_we   <= we_n;
    end
  end

  // monitor: random back-pressure, compare each result beat
  int hold_cnt = 0;
  always @(posedge clk) begin
    seq_out_t got;
    seq_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.bridge = bridge_enable;
        got.pol    = polarity;
        got.dac    = dac_value;
        got.led    = led_state;
        got.sw     = switch_word;
        got.nv     = nodes_valid;
        if (!bridge_enable) gap_results++;
        if (levels_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat %0d: en=%0b pol=%0b dac=%03h led=%0b sw=%04h nv=%0b",
                     results_seen, got.bridge, got.pol, got.dac, got.led, got.sw, got.nv);
        end else begin
          want = levels_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("result beat %0d: expected en=%0b pol=%0b dac=%03h led=%0b sw=%04h nv=%0b",
                       results_seen, want.bridge, want.pol, want.dac, want.led, want.sw, want.nv);
              $display("result beat %0d: actual   en=%0b pol=%0b dac=%03h led=%0b sw=%04h nv=%0b",
                       results_seen, got.bridge, got.pol, got.dac, got.led, got.sw, got.nv);
            end
          end
        end
        results_seen++;
        hold_cnt = rush ? 0 : $urandom_range(0, 10);
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles, pending_q.size());
      $display("** burst_gap_stimulation_pulse_sequencer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    int pwv;
    int bv;
    int gv;
    int npv;
    int nmv;
    logic quick;

    // defaults after reset
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    // short pulse width: every tick ends a period, burst of four, gap of two
    push_write(REG_PULSE_WIDTH, CFG_W'(5));
    push_write(REG_BURST, CFG_W'(20));
    push_write(REG_GAP, CFG_W'(10));
    push_ticks(7);
    // hold freezes everything
    push_write(REG_HOLD, CFG_W'(1));
    push_ticks(2);
    push_write(REG_HOLD, CFG_W'(0));
    // enter a gap, then drop the gap length so the gap is left early
    push_write(REG_GAP, CFG_W'(30));
    push_ticks(5);
    push_write(REG_GAP, CFG_W'(0));
    push_ticks(1);
    // invalid and edge node pairs, amplitude extremes
    push_write(REG_NODE_PLUS, CFG_W'(0));
    push_write(REG_AMPLITUDE, CFG_W'(0));
    push_tick(1'b0, 1'b0);
    push_write(REG_NODE_PLUS, CFG_W'(15));
    push_write(REG_NODE_MINUS, CFG_W'(0));
    push_write(REG_AMPLITUDE, CFG_W'(4095));
    push_tick(1'b0, 1'b0);
    push_write(REG_NODE_PLUS, CFG_W'(3));
    push_write(REG_NODE_MINUS, CFG_W'(3));
    push_tick(1'b0, 1'b0);
    push_write(REG_NODE_PLUS, CFG_W'(8));
    push_write(REG_NODE_MINUS, CFG_W'(1));
    push_tick(1'b1, 1'b0);
    // zero width with zero burst: a gap that never ends
    push_write(REG_PULSE_WIDTH, CFG_W'(0));
    push_write(REG_BURST, CFG_W'(0));
    push_write(REG_GAP, CFG_W'(1));
    push_ticks(2);
    // widest settings
    push_write(REG_PULSE_WIDTH, CFG_W'(65535));
    push_write(REG_BURST, CFG_W'(24'hFFFFFF));
    push_write(REG_GAP, CFG_W'(24'hFFFFFF));
    push_ticks(2);

    // back-to-back beats with no back-pressure
    push_write(REG_PULSE_WIDTH, CFG_W'(5));
    push_write(REG_NODE_PLUS, CFG_W'(2));
    push_write(REG_NODE_MINUS, CFG_W'(7));
    for (int i = 0; i < RUSH_BEATS; i++) push_tick(1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       pwv = $urandom_range(0, 9);
        1:       pwv = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 65535);
        default: pwv = $urandom_range(10, 60);
      endcase
      if ($urandom_range(0, 7) == 0) bv = $urandom_range(0, 24'hFFFFFF);
      else bv = pwv * $urandom_range(0, 6) + $urandom_range(0, 3);
      case ($urandom_range(0, 7))
        0, 1:    gv = 0;
        2:       gv = $urandom_range(1, 24'hFFFFFF);
        default: begin
          gv = pwv * $urandom_range(1, 4) - $urandom_range(0, 2);
          if (gv < 1) gv = 1;
        end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        npv = $urandom_range(1, NODE_COUNT);
        nmv = $urandom_range(1, NODE_COUNT - 1);
        if (nmv >= npv) nmv++;
      end else begin
        npv = $urandom_range(0, 15);
        nmv = $urandom_range(0, 15);
      end
      push_write(REG_PULSE_WIDTH, CFG_W'(pwv));
      push_write(REG_BURST, CFG_W'(bv));
      push_write(REG_GAP, CFG_W'(gv));
      push_write(REG_AMPLITUDE, CFG_W'($urandom_range(0, 4095)));
      push_write(REG_NODE_PLUS, CFG_W'(npv));
      push_write(REG_NODE_MINUS, CFG_W'(nmv));
      push_write(REG_HOLD, CFG_W'($urandom_range(0, 7) == 0));
      quick = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == PHASE_BEATS / 2 && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) != 0) push_write(REG_GAP, CFG_W'($urandom_range(0, 2 * pwv)));
          else push_write(REG_BURST, CFG_W'($urandom_range(0, 8 * pwv)));
        end
        push_tick($urandom_range(0, 3) != 0, quick);
      end
    end

    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_q.size() > 0 || in_valid || levels_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (levels_q.size() > 0) errors++;
    $display("Checked %0d of %0d tick beats across %0d register writes, %0d of them inside a gap.",
             results_seen, beats_sent, writes_done, gap_results);
    $display("Mismatches: %0d.", errors);
    if (errors == 0) begin
      $display("** burst_gap_stimulation_pulse_sequencer_core: PASSED **");
    end else begin
      $display("** burst_gap_stimulation_pulse_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* burst_gap_stimulation_pulse_sequencer_core.f */
+incdir+design
design/bgsps_pkg.sv
design/burst_gap_stimulation_pulse_sequencer_core.sv
test/tb_burst_gap_stimulation_pulse_sequencer_core.sv
